>>> rtl/clcd_pkg.sv
// Shared types, register indexes and LCD command codes for the 4-bit LCD write sequencer.
package clcd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_POWER_ON   = 3'd0;
	localparam logic [2:0] REG_FIRST_INIT = 3'd1;
	localparam logic [2:0] REG_INIT       = 3'd2;
	localparam logic [2:0] REG_ENABLE_HI  = 3'd3;
	localparam logic [2:0] REG_SETTLE     = 3'd4;
	localparam logic [2:0] REG_COMMAND    = 3'd5;
	localparam logic [2:0] REG_CLEAR      = 3'd6;

	localparam logic [15:0] RST_POWER_ON   = 16'd20000;
	localparam logic [15:0] RST_FIRST_INIT = 16'd4000;
	localparam logic [15:0] RST_INIT       = 16'd150;
	localparam logic [15:0] RST_ENABLE_HI  = 16'd1;
	localparam logic [15:0] RST_SETTLE     = 16'd50;
	localparam logic [15:0] RST_COMMAND    = 16'd50;
	localparam logic [15:0] RST_CLEAR      = 16'd2000;

	// LCD command bytes and init nibbles
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_HOME         = 8'h02;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
	localparam logic [3:0] NIB_INIT         = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	// step indexes: last init step, first init command step, last byte step
	localparam logic [4:0] STEP_INIT_LAST = 5'd24;
	localparam logic [4:0] STEP_INIT_CMD  = 5'd9;
	localparam logic [4:0] STEP_BYTE_LAST = 5'd3;

	typedef enum logic [1:0] {
		FUNC_INIT = 2'd0,
		FUNC_CMD  = 2'd1,
		FUNC_DATA = 2'd2,
		FUNC_GOTO = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		BASE_ENABLE = 2'd0,
		BASE_SETTLE = 2'd1,
		BASE_POWER  = 2'd2
	} base_sel_t;

	typedef enum logic [1:0] {
		EXTRA_NONE  = 2'd0,
		EXTRA_FIRST = 2'd1,
		EXTRA_INIT  = 2'd2,
		EXTRA_CMD   = 2'd3
	} extra_sel_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       enable;
		logic       use_const;
		logic [7:0] const_byte;
		logic       hi_nib;
		base_sel_t  base_sel;
		extra_sel_t extra_sel;
		logic       last;
	} step_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// init command bytes, in order
	function automatic logic [7:0] init_cmd(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0:    c = CMD_FUNCTION_SET;
			2'd1:    c = CMD_DISPLAY_ON;
			2'd2:    c = CMD_CLEAR;
			default: c = CMD_ENTRY_MODE;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/char_lcd_4bit_write_sequencer.sv
// Top level of the 4-bit character LCD write sequencer.
// The request is captured in idle; in the run state each step is loaded into the output
// register when it is free. Throughput: one pin step per cycle while out_ready is high;
// init gives 25 steps, other requests 4, and the next request is taken the cycle after
// the last step is loaded.
// The step counter in the controller sets the pace: one output register load per step.
// Reset: timing registers return to their defaults, sequencer idle, no word pending.
module char_lcd_4bit_write_sequencer import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  byte_value,
	input  logic [5:0]  column,
	input  logic        line,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rs_level,
	output logic        enable_level,
	output logic [3:0]  nibble,
	output logic [16:0] hold_us,
	output logic        last
);

	step_cmd_t  cmd;
	dp_status_t status;

	clcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.status   (status),
		.cmd      (cmd)
	);

	clcd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.byte_value   (byte_value),
		.column       (column),
		.line         (line),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rs_level     (rs_level),
		.enable_level (enable_level),
		.nibble       (nibble),
		.hold_us      (hold_us),
		.last         (last)
	);

endmodule

>>> rtl/clcd_ctrl.sv
// Sequencer state machine: walks the pin steps of one request and issues step commands.
module clcd_ctrl import clcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  dp_status_t status,
	output step_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic       init_q;
	logic       extra_cmd_q;
	logic [4:0] nib_rel;
	logic [4:0] rel;
	logic [4:0] last_step;

	assign in_ready  = (state_q == ST_IDLE);
	assign last_step = init_q ? STEP_INIT_LAST : STEP_BYTE_LAST;

	always_comb begin
		cmd         = '0;
		nib_rel     = step_q - 5'd1;
		rel         = init_q ? (step_q - STEP_INIT_CMD) : step_q;
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.load    = (state_q == ST_RUN) && status.out_free;
		cmd.last    = (step_q == last_step);
		if (init_q && step_q == 5'd0) begin
			// power-on wait, pins low
			cmd.use_const = 1'b1;
			cmd.base_sel  = BASE_POWER;
			cmd.extra_sel = EXTRA_NONE;
		end else if (init_q && step_q < STEP_INIT_CMD) begin
			// three 0x3 wake-up nibbles, then 0x2 for 4-bit mode
			cmd.use_const  = 1'b1;
			cmd.enable     = ~nib_rel[0];
			cmd.const_byte = {4'h0, (nib_rel[2:1] == 2'd3) ? NIB_FOUR_BIT : NIB_INIT};
			cmd.base_sel   = nib_rel[0] ? BASE_SETTLE : BASE_ENABLE;
			if (!nib_rel[0]) begin
				cmd.extra_sel = EXTRA_NONE;
			end else if (nib_rel[2:1] == 2'd0) begin
				cmd.extra_sel = EXTRA_FIRST;
			end else if (nib_rel[2:1] == 2'd3) begin
				cmd.extra_sel = EXTRA_NONE;
			end else begin
				cmd.extra_sel = EXTRA_INIT;
			end
		end else begin
			// byte: high E, high settle, low E, low settle
			cmd.use_const  = init_q;
			cmd.const_byte = init_cmd(rel[3:2]);
			cmd.enable     = ~rel[0];
			cmd.hi_nib     = ~rel[1];
			cmd.base_sel   = rel[0] ? BASE_SETTLE : BASE_ENABLE;
			cmd.extra_sel  = (rel[1:0] == 2'd3 && extra_cmd_q) ? EXTRA_CMD : EXTRA_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			init_q      <= 1'b0;
			extra_cmd_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q     <= ST_RUN;
						step_q      <= '0;
						init_q      <= (func == FUNC_INIT);
						extra_cmd_q <= (func != FUNC_DATA);
					end
				end
				ST_RUN: begin
					if (cmd.load) begin
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_byte_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !init_q) |-> step_q <= STEP_BYTE_LAST)
		else $error("byte request step index out of range");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.last) |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after last step");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.last) |=> (state_q == ST_RUN && step_q == $past(step_q) + 5'd1))
		else $error("step index did not advance");

	a_capture_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_RUN && step_q == 5'd0))
		else $error("new request did not start at step zero");

endmodule

>>> rtl/clcd_dpath.sv
// Datapath: timing registers, request latch, hold time adder and output word register.
module clcd_dpath import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  func,
	input  logic [7:0]  byte_value,
	input  logic [5:0]  column,
	input  logic        line,
	input  step_cmd_t   cmd,
	output dp_status_t  status,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        rs_level,
	output logic        enable_level,
	output logic [3:0]  nibble,
	output logic [16:0] hold_us,
	output logic        last
);

	logic [15:0] power_on_q, first_init_q, init_q, enable_hi_q;
	logic [15:0] settle_q, command_q, clear_q;
	logic [7:0]  byte_q;
	logic        rs_q;
	logic        out_valid_q;
	logic        rs_out_q, en_out_q, last_out_q;
	logic [3:0]  nib_out_q;
	logic [16:0] hold_out_q;
	logic [7:0]  byte_sel;
	logic [15:0] base_us;
	logic [15:0] extra_us;
	logic [16:0] hold_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_q   <= RST_POWER_ON;
			first_init_q <= RST_FIRST_INIT;
			init_q       <= RST_INIT;
			enable_hi_q  <= RST_ENABLE_HI;
			settle_q     <= RST_SETTLE;
			command_q    <= RST_COMMAND;
			clear_q      <= RST_CLEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POWER_ON:   power_on_q   <= cfg_data;
				REG_FIRST_INIT: first_init_q <= cfg_data;
				REG_INIT:       init_q       <= cfg_data;
				REG_ENABLE_HI:  enable_hi_q  <= cfg_data;
				REG_SETTLE:     settle_q     <= cfg_data;
				REG_COMMAND:    command_q    <= cfg_data;
				REG_CLEAR:      clear_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// goto address: column + line*0x40 with column below 0x40 is a plain concat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= (func == FUNC_GOTO) ? (CMD_SET_DDRAM | {1'b0, line, column}) : byte_value;
			rs_q   <= (func == FUNC_DATA);
		end
	end

	always_comb begin
		byte_sel = cmd.use_const ? cmd.const_byte : byte_q;
		case (cmd.base_sel)
			BASE_ENABLE: base_us = enable_hi_q;
			BASE_SETTLE: base_us = settle_q;
			BASE_POWER:  base_us = power_on_q;
			default:     base_us = enable_hi_q;
		endcase
		case (cmd.extra_sel)
			EXTRA_NONE:  extra_us = '0;
			EXTRA_FIRST: extra_us = first_init_q;
			EXTRA_INIT:  extra_us = init_q;
			EXTRA_CMD:   extra_us = (byte_sel == CMD_CLEAR || byte_sel == CMD_HOME) ?
				clear_q : command_q;
			default:     extra_us = '0;
		endcase
		// two 16-bit terms never reach the 17-bit ceiling, so no clamp
		hold_sum = {1'b0, base_us} + {1'b0, extra_us};
	end

	assign status.out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rs_out_q   <= rs_q & ~cmd.use_const;
			en_out_q   <= cmd.enable;
			nib_out_q  <= cmd.hi_nib ? byte_sel[7:4] : byte_sel[3:0];
			hold_out_q <= hold_sum;
			last_out_q <= cmd.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign rs_level     = rs_out_q;
	assign enable_level = en_out_q;
	assign nibble       = nib_out_q;
	assign hold_us      = hold_out_q;
	assign last         = last_out_q;

endmodule
